// ===== hdl/jbt_pkg.sv =====
// Shared types and constants of the JSON byte tokenizer.
package jbt_pkg;

    // Record kinds
    typedef enum logic [3:0] {
        K_STRING     = 4'd0,
        K_NAME       = 4'd1,
        K_OBJECT     = 4'd2,
        K_OBJECT_END = 4'd3,
        K_ARRAY      = 4'd4,
        K_ARRAY_END  = 4'd5,
        K_SEPARATOR  = 4'd6,
        K_TRUE       = 4'd7,
        K_FALSE      = 4'd8,
        K_NULL       = 4'd9,
        K_NUMBER     = 4'd10,
        K_UNKNOWN    = 4'd11
    } t_kind;

    // Record status
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    // Quoting phase, one-hot
    typedef enum logic [2:0] {
        QP_OUTSIDE = 3'b001,
        QP_INSIDE  = 3'b010,
        QP_CLOSED  = 3'b100
    } t_quote_phase;

    // Candidate tracking for a bare word
    typedef struct packed {
        logic dot;
        logic maybe;
        logic num;
        logic nul;
        logic fls;
        logic tru;
    } t_word_flags;

    localparam t_word_flags WF_RESET = '{dot: 1'b0, maybe: 1'b1, num: 1'b0,
                                         nul: 1'b1, fls: 1'b1, tru: 1'b1};

    // Keyword spellings, first character in the top byte
    localparam logic [31:0] KW_TRUE  = "true";
    localparam logic [39:0] KW_FALSE = "false";
    localparam logic [31:0] KW_NULL  = "null";

    // Characters of interest
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

endpackage

// ===== hdl/jbt_word_match.sv =====
// Keyword and number-prefix tracking for one character of a bare word.
module jbt_word_match (
    input  logic [7:0]          i_char,
    input  logic [2:0]          i_pos,     // position in word, held at 5 beyond
    input  jbt_pkg::t_word_flags i_flags,
    output jbt_pkg::t_word_flags o_flags
);

    logic [7:0] w_true_ch;
    logic [7:0] w_false_ch;
    logic [7:0] w_null_ch;

    always_comb begin
        case (i_pos)
            3'd0: begin
                w_true_ch  = jbt_pkg::KW_TRUE[31:24];
                w_null_ch  = jbt_pkg::KW_NULL[31:24];
                w_false_ch = jbt_pkg::KW_FALSE[39:32];
            end
            3'd1: begin
                w_true_ch  = jbt_pkg::KW_TRUE[23:16];
                w_null_ch  = jbt_pkg::KW_NULL[23:16];
                w_false_ch = jbt_pkg::KW_FALSE[31:24];
            end
            3'd2: begin
                w_true_ch  = jbt_pkg::KW_TRUE[15:8];
                w_null_ch  = jbt_pkg::KW_NULL[15:8];
                w_false_ch = jbt_pkg::KW_FALSE[23:16];
            end
            3'd3: begin
                w_true_ch  = jbt_pkg::KW_TRUE[7:0];
                w_null_ch  = jbt_pkg::KW_NULL[7:0];
                w_false_ch = jbt_pkg::KW_FALSE[15:8];
            end
            3'd4: begin
                w_true_ch  = jbt_pkg::CH_NUL;
                w_null_ch  = jbt_pkg::CH_NUL;
                w_false_ch = jbt_pkg::KW_FALSE[7:0];
            end
            default: begin
                w_true_ch  = jbt_pkg::CH_NUL;
                w_null_ch  = jbt_pkg::CH_NUL;
                w_false_ch = jbt_pkg::CH_NUL;
            end
        endcase
    end

    always_comb begin
        o_flags     = i_flags;
        // keyword candidates die on any mismatch or beyond their length
        o_flags.tru = i_flags.tru && (i_pos < 3'd4) && (i_char == w_true_ch);
        o_flags.nul = i_flags.nul && (i_pos < 3'd4) && (i_char == w_null_ch);
        o_flags.fls = i_flags.fls && (i_pos < 3'd5) && (i_char == w_false_ch);
        if (!i_flags.num && i_flags.maybe) begin
            if (i_char >= jbt_pkg::CH_ZERO && i_char <= jbt_pkg::CH_NINE) begin
                o_flags.num = 1'b1;
            end else if ((i_char == jbt_pkg::CH_PLUS || i_char == jbt_pkg::CH_MINUS)
                         && i_pos == 3'd0) begin
                o_flags.maybe = 1'b1;
            end else if (i_char == jbt_pkg::CH_DOT && !i_flags.dot) begin
                o_flags.dot = 1'b1;
            end else begin
                o_flags.maybe = 1'b0;
            end
        end
    end

endmodule

// ===== hdl/json_byte_tokenizer.sv =====
// Top level of the JSON byte tokenizer: byte classification, token state and record queue.
//
//  channel   | dir | tdata (low bit up)                                  | tlast
//  ----------+-----+-----------------------------------------------------+-------------
//  s (bytes) | in  | data_byte[7:0]                                      | end_of_data
//  m (recs)  | out | token_kind, token_start, token_length,              | last_of_run
//            |     | nesting_level, scan_status, zero fill to bytes      |
//
// Each accepted byte is classified and the token state advanced in the same cycle; the
// records it causes (zero to three) land in a three-slot result queue.
// A byte that gives at most one record is followed by the next byte in the next cycle
// unless the output stalls. A byte that gives two or three records holds the input
// while the queue drains, one record per cycle when the output is not stalled.
// Reset (i_rst_n low at a clock edge) clears the token state and empties the queue.
// A stalled output holds its record; the input is taken again as the last one leaves.
module json_byte_tokenizer #(
    parameter int MAX_TOKEN_LEN = 256,
    parameter int OFFSET_BITS   = 32,
    localparam int LEN_BITS     = $clog2(MAX_TOKEN_LEN + 1),
    localparam int REC_BITS     = 4 + OFFSET_BITS + LEN_BITS + 8 + 2,
    localparam int TDATA_W      = ((REC_BITS + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte stream
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,   // data_byte[7:0]
    input  logic               i_s_tlast,   // end_of_data
    // record stream
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,   // token_kind, token_start, token_length,
                                            // nesting_level, scan_status, zero fill
    output logic               o_m_tlast    // last_of_run
);

    typedef struct packed {
        jbt_pkg::t_status       status;
        logic signed [7:0]      level;
        logic [LEN_BITS-1:0]    len;
        logic [OFFSET_BITS-1:0] start;
        jbt_pkg::t_kind         kind;
    } t_rec;

    // token state
    logic [OFFSET_BITS-1:0]  r_offset,  n_offset;
    jbt_pkg::t_quote_phase   r_qp,      n_qp;
    logic                    r_esc,     n_esc;
    logic [LEN_BITS-1:0]     r_cnt,     n_cnt;
    logic [OFFSET_BITS-1:0]  r_origin,  n_origin;
    logic signed [7:0]       r_depth,   n_depth;
    jbt_pkg::t_word_flags    r_flags,   n_flags;
    logic                    r_err,     n_err;

    // result queue
    t_rec                    r_slot [3];
    logic [1:0]              r_rd;
    logic [1:0]              r_pend;

    // records of the current byte
    t_rec                    c_rec [3];
    logic [1:0]              c_nrec;

    logic                    w_in_acc;
    logic                    w_out_acc;
    logic                    w_ws;
    logic                    w_ends;
    logic                    w_match_cur;
    logic [2:0]              w_pos;
    jbt_pkg::t_word_flags    w_flags_in;
    jbt_pkg::t_word_flags    w_flags_out;

    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_out_acc = o_m_tvalid && i_m_tready;

    // take a new byte once the queue is empty or its last record leaves now
    assign o_s_tready = (r_pend == 2'd0) || (r_pend == 2'd1 && i_m_tready);
    assign o_m_tvalid = (r_pend != 2'd0);
    assign o_m_tlast  = (r_pend == 2'd1);
    assign o_m_tdata  = TDATA_W'(r_slot[r_rd]);

    assign w_ws = (i_s_tdata == jbt_pkg::CH_SPACE) || (i_s_tdata == jbt_pkg::CH_TAB)
               || (i_s_tdata == jbt_pkg::CH_CR) || (i_s_tdata == jbt_pkg::CH_LF)
               || (i_s_tdata == jbt_pkg::CH_NUL);
    assign w_ends = w_ws || (i_s_tdata == jbt_pkg::CH_LBRACE)
                 || (i_s_tdata == jbt_pkg::CH_RBRACE) || (i_s_tdata == jbt_pkg::CH_LBRACK)
                 || (i_s_tdata == jbt_pkg::CH_RBRACK) || (i_s_tdata == jbt_pkg::CH_COMMA)
                 || (i_s_tdata == jbt_pkg::CH_QUOTE);

    // an open bare word continues from its own flags; a fresh word starts from reset
    assign w_match_cur = (r_qp == jbt_pkg::QP_OUTSIDE) && (r_cnt != '0);
    assign w_pos       = !w_match_cur ? 3'd0 :
                         (r_cnt >= LEN_BITS'(5)) ? 3'd5 : r_cnt[2:0];
    assign w_flags_in  = w_match_cur ? r_flags : jbt_pkg::WF_RESET;

    jbt_word_match u_match (
        .i_char  (i_s_tdata),
        .i_pos   (w_pos),
        .i_flags (w_flags_in),
        .o_flags (w_flags_out)
    );

    // build one record; overlong tokens and a latched error force error status
    function automatic t_rec f_emit(input jbt_pkg::t_kind kind,
                                    input logic [OFFSET_BITS-1:0] start,
                                    input logic [LEN_BITS-1:0] len,
                                    input jbt_pkg::t_status status,
                                    input logic err,
                                    input logic signed [7:0] level);
        t_rec rec;
        rec.kind   = kind;
        rec.start  = start;
        rec.len    = len;
        rec.level  = level;
        rec.status = (err || len >= LEN_BITS'(MAX_TOKEN_LEN - 1)) ? jbt_pkg::ST_ERR : status;
        return rec;
    endfunction

    function automatic logic [LEN_BITS-1:0] f_inc(input logic [LEN_BITS-1:0] cnt);
        return (cnt < LEN_BITS'(MAX_TOKEN_LEN)) ? cnt + LEN_BITS'(1) : cnt;
    endfunction

    // classify a finished bare word; {kind, status}
    function automatic logic [5:0] f_word(input jbt_pkg::t_word_flags f,
                                          input logic [LEN_BITS-1:0] cnt,
                                          input logic at_end);
        logic [5:0] res;
        if (f.tru && cnt == LEN_BITS'(4)) begin
            res = {jbt_pkg::K_TRUE, jbt_pkg::ST_OK};
        end else if (f.fls && cnt == LEN_BITS'(5)) begin
            res = {jbt_pkg::K_FALSE, jbt_pkg::ST_OK};
        end else if (f.nul && cnt == LEN_BITS'(4)) begin
            res = {jbt_pkg::K_NULL, jbt_pkg::ST_OK};
        end else if (at_end) begin
            res = {jbt_pkg::K_UNKNOWN, jbt_pkg::ST_DONE};
        end else if (f.num) begin
            res = {jbt_pkg::K_NUMBER, jbt_pkg::ST_OK};
        end else begin
            res = {jbt_pkg::K_UNKNOWN, jbt_pkg::ST_ERR};
        end
        return res;
    endfunction

    // one byte step: advance the token state and collect its records in order
    always_comb begin
        logic       do_fresh;
        logic       done;
        logic [5:0] wk;

        do_fresh = 1'b0;
        done     = 1'b0;
        wk       = '0;
        n_offset = r_offset + OFFSET_BITS'(1);
        n_qp     = r_qp;
        n_esc    = r_esc;
        n_cnt    = r_cnt;
        n_origin = r_origin;
        n_depth  = r_depth;
        n_flags  = r_flags;
        n_err    = r_err;
        c_nrec   = 2'd0;
        c_rec    = '{default: '0};

        case (r_qp)
            jbt_pkg::QP_INSIDE: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (i_s_tdata == jbt_pkg::CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (i_s_tdata == jbt_pkg::CH_QUOTE) begin
                    n_qp = jbt_pkg::QP_CLOSED;
                end
                if (n_qp == jbt_pkg::QP_INSIDE) begin
                    n_cnt = f_inc(r_cnt);
                end
            end
            jbt_pkg::QP_CLOSED: begin
                // quoted text before ':' is a name, otherwise a string
                c_rec[c_nrec] = f_emit((i_s_tdata == jbt_pkg::CH_COLON) ? jbt_pkg::K_NAME
                                                                        : jbt_pkg::K_STRING,
                                       r_origin, r_cnt, jbt_pkg::ST_OK, n_err, n_depth);
                n_err  = n_err | (c_rec[c_nrec].status == jbt_pkg::ST_ERR);
                c_nrec = c_nrec + 2'd1;
                n_qp    = jbt_pkg::QP_OUTSIDE;
                n_esc   = 1'b0;
                n_cnt   = '0;
                n_flags = jbt_pkg::WF_RESET;
                do_fresh = (i_s_tdata != jbt_pkg::CH_COLON);
            end
            default: begin
                if (r_cnt != '0) begin
                    if (i_s_tdata == jbt_pkg::CH_COLON) begin
                        c_rec[c_nrec] = f_emit(jbt_pkg::K_NAME, r_origin, r_cnt,
                                               jbt_pkg::ST_OK, n_err, n_depth);
                        n_err  = n_err | (c_rec[c_nrec].status == jbt_pkg::ST_ERR);
                        c_nrec = c_nrec + 2'd1;
                        n_cnt   = '0;
                        n_esc   = 1'b0;
                        n_flags = jbt_pkg::WF_RESET;
                    end else if (w_ends) begin
                        wk = f_word(r_flags, r_cnt, 1'b0);
                        c_rec[c_nrec] = f_emit(jbt_pkg::t_kind'(wk[5:2]), r_origin, r_cnt,
                                               jbt_pkg::t_status'(wk[1:0]), n_err, n_depth);
                        n_err  = n_err | (c_rec[c_nrec].status == jbt_pkg::ST_ERR);
                        c_nrec = c_nrec + 2'd1;
                        n_cnt   = '0;
                        n_esc   = 1'b0;
                        n_flags = jbt_pkg::WF_RESET;
                        do_fresh = 1'b1;
                    end else begin
                        n_flags = w_flags_out;
                        n_cnt   = f_inc(r_cnt);
                    end
                end else begin
                    do_fresh = 1'b1;
                end
            end
        endcase

        // byte that arrives with no token open
        if (do_fresh && !w_ws) begin
            if (i_s_tdata == jbt_pkg::CH_LBRACE || i_s_tdata == jbt_pkg::CH_LBRACK) begin
                if (n_depth != 8'sd127) begin
                    n_depth = n_depth + 8'sd1;
                end
                c_rec[c_nrec] = f_emit((i_s_tdata == jbt_pkg::CH_LBRACE) ? jbt_pkg::K_OBJECT
                                                                         : jbt_pkg::K_ARRAY,
                                       r_offset, '0, jbt_pkg::ST_OK, n_err, n_depth);
                n_err  = n_err | (c_rec[c_nrec].status == jbt_pkg::ST_ERR);
                c_nrec = c_nrec + 2'd1;
            end else if (i_s_tdata == jbt_pkg::CH_RBRACE
                         || i_s_tdata == jbt_pkg::CH_RBRACK) begin
                if (n_depth != -8'sd128) begin
                    n_depth = n_depth - 8'sd1;
                end
                c_rec[c_nrec] = f_emit((i_s_tdata == jbt_pkg::CH_RBRACE)
                                           ? jbt_pkg::K_OBJECT_END : jbt_pkg::K_ARRAY_END,
                                       r_offset, '0, jbt_pkg::ST_OK, n_err, n_depth);
                n_err  = n_err | (c_rec[c_nrec].status == jbt_pkg::ST_ERR);
                c_nrec = c_nrec + 2'd1;
            end else if (i_s_tdata == jbt_pkg::CH_COMMA
                         || i_s_tdata == jbt_pkg::CH_COLON) begin
                c_rec[c_nrec] = f_emit((i_s_tdata == jbt_pkg::CH_COMMA)
                                           ? jbt_pkg::K_SEPARATOR : jbt_pkg::K_NAME,
                                       r_offset, '0, jbt_pkg::ST_OK, n_err, n_depth);
                n_err  = n_err | (c_rec[c_nrec].status == jbt_pkg::ST_ERR);
                c_nrec = c_nrec + 2'd1;
            end else if (i_s_tdata == jbt_pkg::CH_QUOTE) begin
                n_qp     = jbt_pkg::QP_INSIDE;
                n_esc    = 1'b0;
                n_cnt    = '0;
                n_flags  = jbt_pkg::WF_RESET;
                n_origin = r_offset + OFFSET_BITS'(1);
            end else begin
                // first character of a bare word
                n_qp     = jbt_pkg::QP_OUTSIDE;
                n_esc    = 1'b0;
                n_origin = r_offset;
                n_flags  = w_flags_out;
                n_cnt    = LEN_BITS'(1);
            end
        end

        // end of document: flush the open token, close with a done record, restart
        if (i_s_tlast) begin
            if (n_qp != jbt_pkg::QP_OUTSIDE) begin
                c_rec[c_nrec] = f_emit(jbt_pkg::K_STRING, n_origin, n_cnt,
                                       jbt_pkg::ST_OK, n_err, n_depth);
                n_err  = n_err | (c_rec[c_nrec].status == jbt_pkg::ST_ERR);
                c_nrec = c_nrec + 2'd1;
            end else if (n_cnt != '0) begin
                wk   = f_word(n_flags, n_cnt, 1'b1);
                done = (wk[1:0] == jbt_pkg::ST_DONE);
                c_rec[c_nrec] = f_emit(jbt_pkg::t_kind'(wk[5:2]), n_origin, n_cnt,
                                       jbt_pkg::t_status'(wk[1:0]), n_err, n_depth);
                n_err  = n_err | (c_rec[c_nrec].status == jbt_pkg::ST_ERR);
                c_nrec = c_nrec + 2'd1;
            end
            if (!done) begin
                c_rec[c_nrec] = f_emit(jbt_pkg::K_UNKNOWN, r_offset + OFFSET_BITS'(1), '0,
                                       jbt_pkg::ST_DONE, n_err, n_depth);
                c_nrec = c_nrec + 2'd1;
            end
            n_offset = '0;
            n_origin = '0;
            n_depth  = '0;
            n_err    = 1'b0;
            n_qp     = jbt_pkg::QP_OUTSIDE;
            n_esc    = 1'b0;
            n_cnt    = '0;
            n_flags  = jbt_pkg::WF_RESET;
        end
    end

    // token state: advance on every byte transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_qp     <= jbt_pkg::QP_OUTSIDE;
            r_esc    <= 1'b0;
            r_cnt    <= '0;
            r_origin <= '0;
            r_depth  <= '0;
            r_flags  <= jbt_pkg::WF_RESET;
            r_err    <= 1'b0;
        end else if (w_in_acc) begin
            r_offset <= n_offset;
            r_qp     <= n_qp;
            r_esc    <= n_esc;
            r_cnt    <= n_cnt;
            r_origin <= n_origin;
            r_depth  <= n_depth;
            r_flags  <= n_flags;
            r_err    <= n_err;
        end
    end

    // result queue control: load a fresh run, else advance on each record transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd   <= 2'd0;
            r_pend <= 2'd0;
        end else if (w_in_acc) begin
            r_rd   <= 2'd0;
            r_pend <= c_nrec;
        end else if (w_out_acc) begin
            r_rd   <= r_rd + 2'd1;
            r_pend <= r_pend - 2'd1;
        end
    end

    // record payload: hold until the next run is loaded
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_slot <= c_rec;
        end
    end

endmodule

// ===== bench/tb_json_byte_tokenizer.sv =====
// Self-checking bench for the JSON byte tokenizer: directed table, random documents, stalls.
`timescale 1ns / 1ps

module tb_json_byte_tokenizer;

    localparam int TOKEN_LEN_CAP = 256;     // length counter ceiling of the block
    localparam int RANDOM_BYTES  = 435;     // least number of bytes to send after the directed table
    localparam int CALM_AFTER    = 400;     // no idling on either side beyond this
    localparam int LONG_HOLD     = 80;      // one long receiver hold-off
    localparam int MAX_REPORTS   = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int TAIL_CYCLES   = 20;

    // One token record as seen on the record stream
    typedef struct packed {
        jbt_pkg::t_kind     kind;
        logic [31:0]        start;
        logic [8:0]         len;
        logic signed [7:0]  level;
        jbt_pkg::t_status   status;
        logic               last;
    } t_token;

    // One row of the directed table; rec is used only where typed is set
    typedef struct {
        logic [7:0] c;
        logic       eod;
        bit         typed;
        t_token     rec;
    } t_row;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [55:0] o_m_tdata;
    logic        o_m_tlast;

    // Tokenizer state as the bench sees it
    logic [31:0]           byte_pos;
    jbt_pkg::t_quote_phase phase;
    bit                    in_escape;
    int unsigned           tok_len;
    logic [31:0]           tok_start;
    logic signed [7:0]     nest;
    jbt_pkg::t_word_flags  wflags;
    bit                    err_seen;
    bit                    word_done;

    t_token step_recs[$];       // records caused by the byte being tokenised
    t_token pending_tokens[$];  // records still owed by the block
    logic [7:0] doc[$];         // document under construction
    t_row dir_rows[25];

    int  fail_count;
    int  cycle_count;
    int  random_items;
    bit  random_phase;
    bit  calm;
    int  hold_left;
    bit  long_hold_done;

    always #5 i_clk = ~i_clk;

    json_byte_tokenizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // ---------------------------------------------------------------- predictor

    function void reset_tokenizer();
        byte_pos  = '0;
        tok_start = '0;
        nest      = '0;
        err_seen  = 1'b0;
        phase     = jbt_pkg::QP_OUTSIDE;
        in_escape = 1'b0;
        tok_len   = 0;
        wflags    = jbt_pkg::WF_RESET;
    endfunction

    function void clear_token();
        phase     = jbt_pkg::QP_OUTSIDE;
        in_escape = 1'b0;
        tok_len   = 0;
        wflags    = jbt_pkg::WF_RESET;
    endfunction

    function bit is_blank(logic [7:0] c);
        return c == jbt_pkg::CH_SPACE || c == jbt_pkg::CH_TAB || c == jbt_pkg::CH_CR
            || c == jbt_pkg::CH_LF || c == jbt_pkg::CH_NUL;
    endfunction

    function void count_char();
        if (tok_len < TOKEN_LEN_CAP) tok_len++;
    endfunction

    // Overlong tokens and anything after a first error carry the error status
    function void emit_token(jbt_pkg::t_kind k, logic [31:0] st, int unsigned ln,
                             jbt_pkg::t_status s);
        t_token t;
        if (ln + 1 >= TOKEN_LEN_CAP) s = jbt_pkg::ST_ERR;
        if (err_seen) s = jbt_pkg::ST_ERR;
        if (s == jbt_pkg::ST_ERR) err_seen = 1'b1;
        t.kind   = k;
        t.start  = st;
        t.len    = ln[8:0];
        t.level  = nest;
        t.status = s;
        t.last   = 1'b0;
        step_recs.push_back(t);
    endfunction

    // Narrow the keyword and number candidates by one more character
    function void word_char(logic [7:0] c);
        int p;
        jbt_pkg::t_word_flags f;
        p = tok_len;
        f = wflags;
        if (!(p < 4 && c == jbt_pkg::KW_TRUE[31 - 8 * p -: 8]))  f.tru = 1'b0;
        if (!(p < 5 && c == jbt_pkg::KW_FALSE[39 - 8 * p -: 8])) f.fls = 1'b0;
        if (!(p < 4 && c == jbt_pkg::KW_NULL[31 - 8 * p -: 8]))  f.nul = 1'b0;
        if (!f.num && f.maybe) begin
            if (c >= jbt_pkg::CH_ZERO && c <= jbt_pkg::CH_NINE) begin
                f.num = 1'b1;
            end else if (!((c == jbt_pkg::CH_PLUS || c == jbt_pkg::CH_MINUS) && p == 0)) begin
                if (c == jbt_pkg::CH_DOT && !f.dot) f.dot = 1'b1;
                else f.maybe = 1'b0;
            end
        end
        wflags = f;
        count_char();
    endfunction

    function void close_word(bit at_end);
        if (wflags.tru && tok_len == 4) begin
            emit_token(jbt_pkg::K_TRUE, tok_start, tok_len, jbt_pkg::ST_OK);
        end else if (wflags.fls && tok_len == 5) begin
            emit_token(jbt_pkg::K_FALSE, tok_start, tok_len, jbt_pkg::ST_OK);
        end else if (wflags.nul && tok_len == 4) begin
            emit_token(jbt_pkg::K_NULL, tok_start, tok_len, jbt_pkg::ST_OK);
        end else if (at_end) begin
            emit_token(jbt_pkg::K_UNKNOWN, tok_start, tok_len, jbt_pkg::ST_DONE);
            word_done = 1'b1;
        end else if (wflags.num) begin
            emit_token(jbt_pkg::K_NUMBER, tok_start, tok_len, jbt_pkg::ST_OK);
        end else begin
            emit_token(jbt_pkg::K_UNKNOWN, tok_start, tok_len, jbt_pkg::ST_ERR);
        end
    endfunction

    // Handle a byte that arrives with no token open
    function void start_token(logic [7:0] c, logic [31:0] off);
        if (is_blank(c)) return;
        if (c == jbt_pkg::CH_LBRACE || c == jbt_pkg::CH_LBRACK) begin
            if (nest != 8'sd127) nest++;
            emit_token(c == jbt_pkg::CH_LBRACE ? jbt_pkg::K_OBJECT : jbt_pkg::K_ARRAY,
                       off, 0, jbt_pkg::ST_OK);
        end else if (c == jbt_pkg::CH_RBRACE || c == jbt_pkg::CH_RBRACK) begin
            if (nest != -8'sd128) nest--;
            emit_token(c == jbt_pkg::CH_RBRACE ? jbt_pkg::K_OBJECT_END : jbt_pkg::K_ARRAY_END,
                       off, 0, jbt_pkg::ST_OK);
        end else if (c == jbt_pkg::CH_COMMA) begin
            emit_token(jbt_pkg::K_SEPARATOR, off, 0, jbt_pkg::ST_OK);
        end else if (c == jbt_pkg::CH_COLON) begin
            emit_token(jbt_pkg::K_NAME, off, 0, jbt_pkg::ST_OK);
        end else if (c == jbt_pkg::CH_QUOTE) begin
            clear_token();
            phase     = jbt_pkg::QP_INSIDE;
            tok_start = off + 32'd1;
        end else begin
            clear_token();
            tok_start = off;
            word_char(c);
        end
    endfunction

    // Advance the tokenizer by one byte; leaves its records in step_recs
    function void tokenize_byte(logic [7:0] c, logic eod);
        logic [31:0] off;
        bit ends;
        off  = byte_pos;
        ends = is_blank(c) || c == jbt_pkg::CH_LBRACE || c == jbt_pkg::CH_RBRACE
            || c == jbt_pkg::CH_LBRACK || c == jbt_pkg::CH_RBRACK
            || c == jbt_pkg::CH_COMMA || c == jbt_pkg::CH_QUOTE;
        step_recs.delete();
        word_done = 1'b0;
        case (phase)
            jbt_pkg::QP_INSIDE: begin
                if (in_escape) in_escape = 1'b0;
                else if (c == jbt_pkg::CH_BSLASH) in_escape = 1'b1;
                else if (c == jbt_pkg::CH_QUOTE) phase = jbt_pkg::QP_CLOSED;
                if (phase == jbt_pkg::QP_INSIDE) count_char();
            end
            jbt_pkg::QP_CLOSED: begin
                if (c == jbt_pkg::CH_COLON) begin
                    emit_token(jbt_pkg::K_NAME, tok_start, tok_len, jbt_pkg::ST_OK);
                    clear_token();
                end else begin
                    emit_token(jbt_pkg::K_STRING, tok_start, tok_len, jbt_pkg::ST_OK);
                    clear_token();
                    start_token(c, off);
                end
            end
            default: begin
                if (tok_len == 0) begin
                    start_token(c, off);
                end else if (c == jbt_pkg::CH_COLON) begin
                    emit_token(jbt_pkg::K_NAME, tok_start, tok_len, jbt_pkg::ST_OK);
                    clear_token();
                end else if (ends) begin
                    close_word(1'b0);
                    clear_token();
                    start_token(c, off);
                end else begin
                    word_char(c);
                end
            end
        endcase

        if (eod) begin
            // flush what is open, close the document, then start afresh
            if (phase != jbt_pkg::QP_OUTSIDE) begin
                emit_token(jbt_pkg::K_STRING, tok_start, tok_len, jbt_pkg::ST_OK);
            end else if (tok_len > 0) begin
                close_word(1'b1);
            end
            if (!word_done) emit_token(jbt_pkg::K_UNKNOWN, off + 32'd1, 0, jbt_pkg::ST_DONE);
            reset_tokenizer();
        end else begin
            byte_pos = off + 32'd1;
        end

        if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------- document builders

    function automatic void push_blank();
        case ($urandom_range(0, 7))
            0: doc.push_back(jbt_pkg::CH_SPACE);
            1: doc.push_back(jbt_pkg::CH_TAB);
            2: doc.push_back(jbt_pkg::CH_LF);
            3: doc.push_back(jbt_pkg::CH_CR);
            4: doc.push_back(jbt_pkg::CH_NUL);
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] pool[14];
        pool = '{jbt_pkg::CH_QUOTE, jbt_pkg::CH_COLON, jbt_pkg::CH_COMMA,
                 jbt_pkg::CH_LBRACE, jbt_pkg::CH_RBRACE, jbt_pkg::CH_LBRACK,
                 jbt_pkg::CH_RBRACK, jbt_pkg::CH_BSLASH, jbt_pkg::CH_PLUS,
                 jbt_pkg::CH_MINUS, jbt_pkg::CH_DOT, jbt_pkg::CH_ZERO,
                 jbt_pkg::CH_SPACE, "t"};
        if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 13)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void push_text(int n);
        logic [7:0] c;
        doc.push_back(jbt_pkg::CH_QUOTE);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 6) == 0) begin
                // an escape pair: the escaped byte may be anything, a quote too
                doc.push_back(jbt_pkg::CH_BSLASH);
                doc.push_back(8'($urandom_range(0, 255)));
            end else begin
                c = 8'($urandom_range(32, 126));
                if (c == jbt_pkg::CH_QUOTE || c == jbt_pkg::CH_BSLASH) c = "q";
                doc.push_back(c);
            end
        end
        doc.push_back(jbt_pkg::CH_QUOTE);
    endfunction

    function automatic void push_word(string w);
        foreach (w[i]) doc.push_back(w[i]);
    endfunction

    function automatic void push_digits();
        repeat ($urandom_range(1, 3))
            doc.push_back(8'($urandom_range(jbt_pkg::CH_ZERO, jbt_pkg::CH_NINE)));
    endfunction

    function automatic void push_number();
        case ($urandom_range(0, 5))
            0: doc.push_back(jbt_pkg::CH_MINUS);
            1: doc.push_back(jbt_pkg::CH_PLUS);
            default: ;
        endcase
        if ($urandom_range(0, 4) == 0) doc.push_back(jbt_pkg::CH_DOT);
        push_digits();
        if ($urandom_range(0, 2) == 0) begin
            doc.push_back(jbt_pkg::CH_DOT);
            push_digits();
        end
    endfunction

    function automatic void push_value(int lvl);
        int r;
        int n;
        r = $urandom_range(0, 9);
        if (lvl >= 3 && r >= 6) r = r - 6;
        case (r)
            0, 1: push_text($urandom_range(0, 6));
            2: begin
                case ($urandom_range(0, 2))
                    0: push_word("true");
                    1: push_word("false");
                    default: push_word("null");
                endcase
            end
            3, 4, 5: push_number();
            6, 7: begin
                n = $urandom_range(0, 3);
                doc.push_back(jbt_pkg::CH_LBRACE);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) doc.push_back(jbt_pkg::CH_COMMA);
                    push_blank();
                    push_text($urandom_range(0, 4));
                    push_blank();
                    doc.push_back(jbt_pkg::CH_COLON);
                    push_blank();
                    push_value(lvl + 1);
                    push_blank();
                end
                doc.push_back(jbt_pkg::CH_RBRACE);
            end
            default: begin
                n = $urandom_range(0, 4);
                doc.push_back(jbt_pkg::CH_LBRACK);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) doc.push_back(jbt_pkg::CH_COMMA);
                    push_blank();
                    push_value(lvl + 1);
                    push_blank();
                end
                doc.push_back(jbt_pkg::CH_RBRACK);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------ sender

    // Offer one byte, wait for its transfer, then book the records it owes
    task automatic send_byte(logic [7:0] c, logic eod, bit typed, t_token typed_rec);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eod;
        do @(posedge i_clk); while (!o_s_tready);
        tokenize_byte(c, eod);
        if (typed) pending_tokens.push_back(typed_rec);
        else foreach (step_recs[i]) pending_tokens.push_back(step_recs[i]);
    endtask

    task automatic send_doc();
        foreach (doc[i]) send_byte(doc[i], i == doc.size() - 1, 1'b0, '0);
    endtask

    // ---------------------------------------------------------------- receiver

    always @(posedge i_clk) begin : record_side
        t_token got;
        t_token want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got.kind   = jbt_pkg::t_kind'(o_m_tdata[3:0]);
            got.start  = o_m_tdata[35:4];
            got.len    = o_m_tdata[44:36];
            got.level  = o_m_tdata[52:45];
            got.status = jbt_pkg::t_status'(o_m_tdata[54:53]);
            got.last   = o_m_tlast;
            if (pending_tokens.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected record: kind %0d start %0d len %0d lvl %0d st %0d",
                             got.kind, got.start, got.len, got.level, got.status);
            end else begin
                want = pending_tokens.pop_front();
                if (got.kind !== want.kind || got.start !== want.start
                        || got.len !== want.len || got.level !== want.level
                        || got.status !== want.status || got.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("expected kind %0d start %0d len %0d lvl %0d st %0d last %0b",
                                 want.kind, want.start, want.len, want.level, want.status,
                                 want.last);
                        $display("actual   kind %0d start %0d len %0d lvl %0d st %0d last %0b",
                                 got.kind, got.start, got.len, got.level, got.status,
                                 got.last);
                    end
                end
            end
        end

        // choose ready for the next cycle; one long hold-off once random traffic starts
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (random_phase && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            m_tready       <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 4);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[json_byte_tokenizer] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin : stimulus
        int kind_pick;
        int cut;
        int doc_no;

        reset_tokenizer();
        fail_count     = 0;
        cycle_count    = 0;
        random_items   = 0;
        random_phase   = 1'b0;
        calm           = 1'b0;
        hold_left      = 0;
        long_hold_done = 1'b0;

        // Directed: empty name, escaped quote, quote ending a bare word, latched error,
        // end inside a string, bare word at end, just-closed string at end, negative depth.
        dir_rows = '{
            '{jbt_pkg::CH_LBRACE, 1'b0, 1'b1,
              '{jbt_pkg::K_OBJECT, 32'd0, 9'd0, 8'sd1, jbt_pkg::ST_OK, 1'b1}},
            '{jbt_pkg::CH_COLON,  1'b0, 1'b1,
              '{jbt_pkg::K_NAME, 32'd1, 9'd0, 8'sd1, jbt_pkg::ST_OK, 1'b1}},
            '{jbt_pkg::CH_QUOTE,  1'b0, 1'b0, '0},
            '{jbt_pkg::CH_BSLASH, 1'b0, 1'b0, '0},
            '{jbt_pkg::CH_QUOTE,  1'b0, 1'b0, '0},
            '{jbt_pkg::CH_QUOTE,  1'b0, 1'b0, '0},
            '{jbt_pkg::CH_COMMA,  1'b0, 1'b0, '0},
            '{"a",                1'b0, 1'b0, '0},
            '{jbt_pkg::CH_QUOTE,  1'b0, 1'b1,
              '{jbt_pkg::K_UNKNOWN, 32'd7, 9'd1, 8'sd1, jbt_pkg::ST_ERR, 1'b1}},
            '{"b",                1'b0, 1'b0, '0},
            '{jbt_pkg::CH_QUOTE,  1'b0, 1'b0, '0},
            '{jbt_pkg::CH_QUOTE,  1'b0, 1'b0, '0},
            '{8'hFF,              1'b0, 1'b0, '0},
            '{jbt_pkg::CH_SPACE,  1'b0, 1'b0, '0},
            '{jbt_pkg::CH_RBRACK, 1'b1, 1'b0, '0},
            '{"n",                1'b0, 1'b0, '0},
            '{"u",                1'b0, 1'b0, '0},
            '{"l",                1'b0, 1'b0, '0},
            '{"l",                1'b0, 1'b0, '0},
            '{jbt_pkg::CH_TAB,    1'b0, 1'b0, '0},
            '{"5",                1'b1, 1'b1,
              '{jbt_pkg::K_UNKNOWN, 32'd5, 9'd1, 8'sd0, jbt_pkg::ST_DONE, 1'b1}},
            '{jbt_pkg::CH_QUOTE,  1'b0, 1'b0, '0},
            '{jbt_pkg::CH_QUOTE,  1'b0, 1'b0, '0},
            '{jbt_pkg::CH_NUL,    1'b1, 1'b0, '0},
            '{jbt_pkg::CH_RBRACE, 1'b1, 1'b0, '0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].c, dir_rows[i].eod, dir_rows[i].typed, dir_rows[i].rec);

        random_phase = 1'b1;
        doc_no = 0;
        while (random_items < RANDOM_BYTES) begin
            doc.delete();
            case (doc_no)
                0: repeat (130) doc.push_back(jbt_pkg::CH_LBRACE);    // depth saturates high
                1: begin
                    // a bare word that runs past the length ceiling, ended by a bracket
                    repeat (TOKEN_LEN_CAP + 1)
                        doc.push_back(8'($urandom_range(jbt_pkg::CH_ZERO, jbt_pkg::CH_NINE)));
                    doc.push_back(jbt_pkg::CH_RBRACE);
                end
                default: begin
                    kind_pick = $urandom_range(0, 19);
                    if (kind_pick < 3) begin
                        repeat ($urandom_range(1, 16)) doc.push_back(noise_byte());
                    end else begin
                        push_blank();
                        push_value(0);
                        push_blank();
                        if (kind_pick < 5) begin
                            cut = $urandom_range(1, doc.size());
                            while (doc.size() > cut) void'(doc.pop_back());
                        end else if (kind_pick < 7) begin
                            doc[$urandom_range(0, doc.size() - 1)] = noise_byte();
                        end
                    end
                end
            endcase
            send_doc();
            random_items += doc.size();
            if (random_items >= CALM_AFTER) calm = 1'b1;
            doc_no++;
        end
        s_tvalid <= 1'b0;

        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[json_byte_tokenizer] OK");
        end else begin
            $display("[json_byte_tokenizer] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/jbt_pkg.sv
hdl/jbt_word_match.sv
hdl/json_byte_tokenizer.sv
bench/tb_json_byte_tokenizer.sv
